// ===== src/assert_macros.svh =====
// assertion helpers for the interpolator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/pli_pkg.sv =====
`timescale 1ns / 1ps

package pli_pkg;

  // signed q16.16 word
  typedef logic signed [31:0] q16_t;

  // command codes carried in s_tuser
  typedef enum logic {
    CMD_EVALUATE = 1'b0,
    CMD_LOAD     = 1'b1
  } cmd_t;

  // clip limits of a q16.16 word
  localparam q16_t Q_MAX = 32'sh7fff_ffff;
  localparam q16_t Q_MIN = 32'sh8000_0000;

  // rounding bias for the q33.32 product (half of one q16.16 lsb)
  localparam logic signed [64:0] ROUND_BIAS = 65'sd32768;

endpackage

// ===== src/piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps
// piecewise linear interpolator, signed q16.16
// slave channel s_*: s_tuser is the command (0 evaluate, 1 load breakpoint),
//   s_tdata carries point_index, x_value, point_value, point_slope.
// a load writes one breakpoint (x, value, outgoing slope) at the transaction
//   edge and gives no result; an evaluate gives one result on m_*.
// master channel m_*: m_tdata is function_value, m_tuser is the saturated flag.
// cfg_we / cfg_data write segments_in_use; write it only while no evaluate
//   is in flight.
// throughput: one transaction per cycle of either kind unless a stalled receiver
//   has filled the stages, set by a six-stage pipeline (parallel lane compares,
//   first-hit select and table read, offset, multiply, rounding, add and clip).
// an evaluate's result is presented from the output register, which closes the add and clip stage.
// a stalled receiver holds the output register; bubbles left by loads are
//   squeezed out, so the input keeps taking items until the stages fill.
// reset (synchronous, active high) empties the pipeline and clears
//   segments_in_use; breakpoint tables hold no defined contents until loaded.
module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_SEGMENTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic [3:0]   cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [3:0] point_index, [35:4] x_value, [67:36] point_value,
  // [99:68] point_slope, [103:100] zero
  input  logic [103:0] s_tdata,
  // [0] command
  input  logic [0:0]   s_tuser,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] function_value
  output logic [31:0]  m_tdata,
  // [0] saturated
  output logic [0:0]   m_tuser
);

  localparam int NP = MAX_SEGMENTS + 1;
  localparam int NW = (NP > 1) ? $clog2(NP) : 1;

  // input field split
  logic [3:0] in_index;
  q16_t       in_x;
  q16_t       in_val;
  q16_t       in_slope;
  cmd_t       in_cmd;

  assign in_index = s_tdata[3:0];
  assign in_x     = q16_t'(s_tdata[35:4]);
  assign in_val   = q16_t'(s_tdata[67:36]);
  assign in_slope = q16_t'(s_tdata[99:68]);
  assign in_cmd   = cmd_t'(s_tuser[0]);

  // configuration register
  logic [3:0] segments_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= '0;
    end else if (cfg_we) begin
      segments_in_use <= cfg_data;
    end
  end

  // stage enables, each stage moves when it is empty or its successor moves
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || m_tready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign s_tready = en1;

  logic s_accept;
  logic load_accept;
  logic eval_accept;

  assign s_accept    = s_tvalid && s_tready;
  assign load_accept = s_accept && (in_cmd == CMD_LOAD);
  assign eval_accept = s_accept && (in_cmd == CMD_EVALUATE);

  // breakpoint tables
  q16_t bp_x     [NP];
  q16_t bp_value [NP];
  q16_t bp_slope [MAX_SEGMENTS];

  // breakpoint load, an index past the table writes nothing
  always_ff @(posedge clk) begin
    if (load_accept) begin
      for (int k = 0; k < NP; k++) begin
        if (int'(in_index) == k) begin
          bp_x[k]     <= in_x;
          bp_value[k] <= in_val;
        end
      end
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        if (int'(in_index) == k) begin
          bp_slope[k] <= in_slope;
        end
      end
    end
  end

  // stage 1: clamp segment count and compare x against every breakpoint
  logic [NW-1:0] n_next;
  logic [NP-1:0] gt_next;
  logic [NP-1:0] ge_next;

  always_comb begin
    int n_int;
    n_int = (int'(segments_in_use) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(segments_in_use);
    n_next = NW'(n_int);
    for (int k = 0; k < NP; k++) begin
      gt_next[k] = (in_x > bp_x[k]);
      ge_next[k] = (in_x >= bp_x[k]);
    end
  end

  q16_t          x1;
  logic [NW-1:0] n1;
  logic [NP-1:0] gt1;
  logic [NP-1:0] ge1;

  always_ff @(posedge clk) begin
    if (en1) begin
      x1  <= in_x;
      n1  <= n_next;
      gt1 <= gt_next;
      ge1 <= ge_next;
    end
  end

  // stage 2: first breakpoint not below x, pick the segment and read tables
  logic [NP-1:0] not_gt;
  logic [NP-1:0] onehot_n;
  logic [NP-1:0] first_hit;
  logic [NP-1:0] sel;
  logic          at_last;
  logic          identity;
  logic          interp_next;
  q16_t          bx_sel;
  q16_t          val_sel;
  q16_t          slp_sel;
  q16_t          val_next;

  always_comb begin
    not_gt   = '0;
    onehot_n = '0;
    for (int k = 0; k < NP; k++) begin
      if (k == int'(n1)) begin
        not_gt[k]   = 1'b1;
        onehot_n[k] = 1'b1;
      end else if (k < int'(n1)) begin
        not_gt[k] = !gt1[k];
      end
    end
    // isolate the lowest set bit
    first_hit = not_gt & (~not_gt + NP'(1));
    at_last   = ge1[n1];
    identity  = (n1 == '0);

    priority if (at_last) begin
      sel = onehot_n;
    end else if (first_hit[0]) begin
      sel = first_hit;
    end else begin
      sel = first_hit >> 1;
    end
    interp_next = !identity && !at_last && !first_hit[0];

    bx_sel  = '0;
    val_sel = '0;
    slp_sel = '0;
    for (int k = 0; k < NP; k++) begin
      if (sel[k]) begin
        bx_sel  = bx_sel | bp_x[k];
        val_sel = val_sel | bp_value[k];
      end
    end
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (sel[k]) begin
        slp_sel = slp_sel | bp_slope[k];
      end
    end
    // the identity case passes x straight through
    val_next = identity ? x1 : val_sel;
  end

  q16_t x2;
  q16_t bx2;
  q16_t val2;
  q16_t slp2;
  logic interp2;

  always_ff @(posedge clk) begin
    if (en2) begin
      x2      <= x1;
      bx2     <= bx_sel;
      val2    <= val_next;
      slp2    <= slp_sel;
      interp2 <= interp_next;
    end
  end

  // stage 3: exact offset from the segment start
  logic signed [32:0] off_next;

  assign off_next = 33'(x2) - 33'(bx2);

  logic signed [32:0] off3;
  q16_t               slp3;
  q16_t               val3;
  logic               interp3;

  always_ff @(posedge clk) begin
    if (en3) begin
      off3    <= off_next;
      slp3    <= slp2;
      val3    <= val2;
      interp3 <= interp2;
    end
  end

  // stage 4: slope times offset, exact q33.32
  logic signed [64:0] prod_next;

  assign prod_next = 65'(off3) * 65'(slp3);

  logic signed [64:0] prod4;
  q16_t               val4;
  logic               interp4;

  always_ff @(posedge clk) begin
    if (en4) begin
      prod4   <= prod_next;
      val4    <= val3;
      interp4 <= interp3;
    end
  end

  // stage 5: round to q16.16, ties toward plus infinity
  logic signed [48:0] q_next;

  assign q_next = 49'((prod4 + ROUND_BIAS) >>> 16);

  logic signed [48:0] q5;
  q16_t               val5;
  logic               interp5;

  always_ff @(posedge clk) begin
    if (en5) begin
      q5      <= q_next;
      val5    <= val4;
      interp5 <= interp4;
    end
  end

  // stage 6: add breakpoint value and clip for an interpolated point, else pass the value
  logic signed [49:0] sum;
  q16_t               res_next;
  logic               sat_next;

  always_comb begin
    sum = 50'(q5) + 50'(val5);
    res_next = val5;
    sat_next = 1'b0;
    if (interp5) begin
      priority if (sum > 50'(Q_MAX)) begin
        res_next = Q_MAX;
        sat_next = 1'b1;
      end else if (sum < 50'(Q_MIN)) begin
        res_next = Q_MIN;
        sat_next = 1'b1;
      end else begin
        res_next = q16_t'(sum[31:0]);
      end
    end
  end

  // output register
  q16_t out_val;
  logic out_sat;

  always_ff @(posedge clk) begin
    if (en6) begin
      out_val <= res_next;
      out_sat <= sat_next;
    end
  end

  assign m_tvalid   = v6;
  assign m_tdata    = out_val;
  assign m_tuser[0] = out_sat;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= eval_accept;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // checks
  `include "assert_macros.svh"

  // a load never occupies a pipeline slot
  `ASSERT_NEXT(a_load_no_slot, clk, rst, load_accept, !v1)

  // a clipped result sits at one of the two limits
  `ASSERT_IMPLIES(a_sat_at_limit, clk, rst, m_tvalid && m_tuser[0],
    (m_tdata == 32'h7fff_ffff) || (m_tdata == 32'h8000_0000))

  // only interpolated values can be flagged as clipped
  `ASSERT_NEXT(a_sat_only_interp, clk, rst, en6 && v5 && !interp5, !out_sat)

endmodule
